[rtl/core/csct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_pkg - shared types and constants
// Defaults and flag bundle for the Collins-Soper cos(theta) datapath.
// ----------------------------------------------------------------------------
package csct_pkg;

    localparam int MOMENTUM_WIDTH_DEF = 20;
    localparam int COS_FRAC_BITS_DEF  = 15;
    localparam int COS_WIDTH          = 16;

    // per-item side flags carried down the pipeline
    typedef struct packed {
        logic bad;      // denominator not positive
        logic num_neg;  // numerator negative
        logic z_neg;    // pair longitudinal momentum negative
    } flags_t;

endpackage

[rtl/core/collins_soper_cos_theta.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collins_soper_cos_theta - Collins-Soper cos(theta) of a lepton pair
// Exact integer kinematics, then a bit-per-stage search for the rounded
// Q1.15 quotient num / sqrt(M2 * (M2 + qt2)), saturated to the Q1.15 range.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: both lepton four-momenta
//  m_        out  m_tvalid/m_tready  m_tdata: cos_theta, m_tuser: bad_kinematics
//  cfg_      in   cfg_valid/ready    cfg_data: flip_enable
//
//  One request per cycle sustained while m_tready does not stall the output.
//  The pipe has seven kinematics stages, one search stage per
//  quotient bit (COS_FRAC_BITS + 1 of them) and one output register.
//  Reset (aresetn low, synchronous) drops all requests in flight and sets
//  flip_enable. A stall on m_tready holds the output; bubbles further up
//  still close, so s_tready stays high until the pipe is really full.
// ----------------------------------------------------------------------------
module collins_soper_cos_theta #(
    parameter int MOMENTUM_WIDTH = csct_pkg::MOMENTUM_WIDTH_DEF,
    parameter int COS_FRAC_BITS  = csct_pkg::COS_FRAC_BITS_DEF,
    localparam int S_DW = ((8 * MOMENTUM_WIDTH - 2 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // plus_px, plus_py, plus_pz, plus_energy, minus_px, minus_py, minus_pz,
    // minus_energy, zero pad
    input  logic [S_DW-1:0]                s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cos_theta
    output logic [csct_pkg::COS_WIDTH-1:0] m_tdata,
    // bad_kinematics
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);
    import csct_pkg::*;

    localparam int W   = MOMENTUM_WIDTH;
    localparam int F   = COS_FRAC_BITS;
    localparam int W1  = W + 1;
    localparam int W2  = 2 * W + 2;
    localparam int W3  = 2 * W + 3;
    localparam int AW  = W3;
    localparam int HW  = W + 2;
    localparam int CW  = 2 * AW + 2 * F + 5;
    localparam int KW  = F + 1;
    localparam int NS  = F + 9;

    // ---------------- handshake and valid pipe ----------------
    logic [NS:1]   valid_reg;
    logic [NS+1:1] rdy;
    logic [NS:1]   vin;
    logic          flip_reg;

    always_comb begin
        rdy[NS+1] = m_tready;
        for (int j = NS; j >= 1; j--) begin
            rdy[j] = !valid_reg[j] || rdy[j+1];
        end
    end

    assign vin       = {valid_reg[NS-1:1], s_tvalid};
    assign s_tready  = rdy[1];
    assign m_tvalid  = valid_reg[NS];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            flip_reg  <= 1'b1;
        end else begin
            valid_reg <= (valid_reg & ~rdy[NS:1]) | (vin & rdy[NS:1]);
            if (cfg_valid) begin
                flip_reg <= cfg_data;
            end
        end
    end

    // ---------------- field unpack ----------------
    logic signed [W-1:0] pxp, pyp, pzp, pxm, pym, pzm;
    logic        [W-2:0] ep, em;
    logic signed [W1-1:0] epx, emx;

    assign pxp = signed'(s_tdata[W-1:0]);
    assign pyp = signed'(s_tdata[2*W-1:W]);
    assign pzp = signed'(s_tdata[3*W-1:2*W]);
    assign ep  = s_tdata[4*W-2:3*W];
    assign pxm = signed'(s_tdata[5*W-2:4*W-1]);
    assign pym = signed'(s_tdata[6*W-2:5*W-1]);
    assign pzm = signed'(s_tdata[7*W-2:6*W-1]);
    assign em  = s_tdata[8*W-3:7*W-1];
    assign epx = signed'(W1'(ep));
    assign emx = signed'(W1'(em));

    // ---------------- stage 1: pair sums, light-cone terms ----------------
    logic        [W-1:0]  e_reg;
    logic signed [W1-1:0] x_reg, y_reg, a_reg, b_reg, c_reg, d_reg;
    logic                 zn1_reg;
    logic signed [W1-1:0] z_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            e_reg   <= W'(ep) + W'(em);
            x_reg   <= W1'(pxp) + W1'(pxm);
            y_reg   <= W1'(pyp) + W1'(pym);
            z_reg   <= W1'(pzp) + W1'(pzm);
            a_reg   <= emx + W1'(pzm);
            b_reg   <= epx - W1'(pzp);
            c_reg   <= emx - W1'(pzm);
            d_reg   <= epx + W1'(pzp);
        end
    end
    assign zn1_reg = z_reg[W1-1];

    // ---------------- stage 2: products ----------------
    logic signed [W2-1:0] ab_reg, cd_reg, x2_reg, y2_reg, z2_reg;
    logic        [2*W-1:0] e2_reg;
    logic                  zn2_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            ab_reg  <= W2'(a_reg) * W2'(b_reg);
            cd_reg  <= W2'(c_reg) * W2'(d_reg);
            x2_reg  <= W2'(x_reg) * W2'(x_reg);
            y2_reg  <= W2'(y_reg) * W2'(y_reg);
            z2_reg  <= W2'(z_reg) * W2'(z_reg);
            e2_reg  <= (2*W)'(e_reg) * (2*W)'(e_reg);
            zn2_reg <= zn1_reg;
        end
    end

    // ---------------- stage 3: numerator, mt2, qt2 ----------------
    logic signed [W3-1:0] num_reg, qt2_reg;
    logic signed [W2-1:0] mt2_reg;
    logic                 zn3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            num_reg <= W3'(ab_reg) - W3'(cd_reg);
            qt2_reg <= W3'(x2_reg) + W3'(y2_reg);
            mt2_reg <= signed'(W2'(e2_reg)) - z2_reg;
            zn3_reg <= zn2_reg;
        end
    end

    // ---------------- stage 4: M2, numerator magnitude ----------------
    logic signed [W3-1:0] m2_reg;
    logic signed [W2-1:0] mt2b_reg;
    logic        [AW-1:0] an4_reg;
    flags_t               fl4_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            m2_reg       <= W3'(mt2_reg) - qt2_reg;
            mt2b_reg     <= mt2_reg;
            an4_reg      <= num_reg[W3-1] ? AW'(-num_reg) : AW'(num_reg);
            fl4_reg.bad     <= 1'b0;
            fl4_reg.num_neg <= num_reg[W3-1];
            fl4_reg.z_neg   <= zn3_reg;
        end
    end

    // ---------------- stage 5: magnitudes, denominator sign ----------------
    logic [AW-1:0] m2a_reg, mta_reg, an5_reg;
    flags_t        fl5_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            m2a_reg <= m2_reg[W3-1] ? AW'(-m2_reg) : AW'(m2_reg);
            mta_reg <= mt2b_reg[W2-1] ? AW'(-W3'(mt2b_reg)) : AW'(W3'(mt2b_reg));
            an5_reg <= an4_reg;
            fl5_reg.num_neg <= fl4_reg.num_neg;
            fl5_reg.z_neg   <= fl4_reg.z_neg;
            // positive only when both factors nonzero with equal signs
            fl5_reg.bad     <= (m2_reg == '0) || (mt2b_reg == '0)
                               || (m2_reg[W3-1] != mt2b_reg[W2-1]);
        end
    end

    // ---------------- stage 6: split partial products ----------------
    logic [2*HW-1:0] dll_reg, dlh_reg, dhl_reg, dhh_reg, all_reg, alh_reg, ahh_reg;
    flags_t          fl6_reg;
    logic [HW-1:0]   mlo, tlo, alo, mhi, thi, ahi;

    assign mlo = m2a_reg[HW-1:0];
    assign tlo = mta_reg[HW-1:0];
    assign alo = an5_reg[HW-1:0];
    assign mhi = HW'(m2a_reg[AW-1:HW]);
    assign thi = HW'(mta_reg[AW-1:HW]);
    assign ahi = HW'(an5_reg[AW-1:HW]);

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            dll_reg <= (2*HW)'(mlo) * (2*HW)'(tlo);
            dlh_reg <= (2*HW)'(mlo) * (2*HW)'(thi);
            dhl_reg <= (2*HW)'(mhi) * (2*HW)'(tlo);
            dhh_reg <= (2*HW)'(mhi) * (2*HW)'(thi);
            all_reg <= (2*HW)'(alo) * (2*HW)'(alo);
            alh_reg <= (2*HW)'(alo) * (2*HW)'(ahi);
            ahh_reg <= (2*HW)'(ahi) * (2*HW)'(ahi);
            fl6_reg <= fl5_reg;
        end
    end

    // ---------------- stage 7: den and scaled num^2 ----------------
    logic [CW-1:0] p_a  [0:KW];
    logic [CW-1:0] dk_a [0:KW];
    logic [CW-1:0] dd_a [0:KW];
    logic [CW-1:0] rr_a [0:KW];
    logic [KW-1:0] k_a  [0:KW];
    flags_t        fl_a [0:KW];

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            dd_a[0] <= (CW'(dhh_reg) << (2*HW)) + ((CW'(dlh_reg) + CW'(dhl_reg)) << HW)
                       + CW'(dll_reg);
            rr_a[0] <= ((CW'(ahh_reg) << (2*HW)) + (CW'(alh_reg) << (HW+1))
                       + CW'(all_reg)) << (2*F+2);
            p_a[0]  <= '0;
            dk_a[0] <= '0;
            k_a[0]  <= '0;
            fl_a[0] <= fl6_reg;
        end
    end

    // ---------------- stages 8 .. F+8: quotient search, MSB first ----------------
    for (genvar i = 0; i < KW; i++) begin : g_srch
        csct_srch #(
            .CW (CW),
            .KW (KW),
            .BIT(F - i)
        ) u_srch (
            .aclk     (aclk),
            .adv      (rdy[8+i]),
            .d_in     (dd_a[i]),
            .r_in     (rr_a[i]),
            .p_in     (p_a[i]),
            .dk_in    (dk_a[i]),
            .k_in     (k_a[i]),
            .flags_in (fl_a[i]),
            .d_reg    (dd_a[i+1]),
            .r_reg    (rr_a[i+1]),
            .p_reg    (p_a[i+1]),
            .dk_reg   (dk_a[i+1]),
            .k_reg    (k_a[i+1]),
            .flags_reg(fl_a[i+1])
        );
    end

    // ---------------- output stage: sign, saturate ----------------
    logic [KW-1:0] mag;
    logic [KW-1:0] pos_sat;
    logic          neg;
    logic [31:0]   val_next;
    flags_t        flo;
    logic [COS_WIDTH-1:0] cos_reg;
    logic                 bad_reg;

    always_comb begin
        mag     = k_a[KW];
        flo     = fl_a[KW];
        neg     = flo.num_neg ^ (flip_reg && flo.z_neg);
        pos_sat = mag[KW-1] ? ((KW'(1) << F) - KW'(1)) : mag;
        if (flo.bad) begin
            val_next = '0;
        end else if (neg) begin
            val_next = 32'(0) - 32'(mag);
        end else begin
            val_next = 32'(pos_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NS]) begin
            cos_reg <= val_next[COS_WIDTH-1:0];
            bad_reg <= flo.bad;
        end
    end

    assign m_tdata = cos_reg;
    assign m_tuser = bad_reg;

endmodule

[rtl/core/csct_srch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_srch - one bit of the rounded quotient search
// Tries to set bit BIT of k, keeping (2k-1)^2 * D <= R, with P = D*(4k^2-4k)
// and DK = D*k updated incrementally so only shifts and adds are needed.
// ----------------------------------------------------------------------------
module csct_srch #(
    parameter int CW  = 121,
    parameter int KW  = 16,
    parameter int BIT = 0
) (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic [CW-1:0]          d_in,
    input  logic [CW-1:0]          r_in,
    input  logic [CW-1:0]          p_in,
    input  logic [CW-1:0]          dk_in,
    input  logic [KW-1:0]          k_in,
    input  csct_pkg::flags_t       flags_in,
    output logic [CW-1:0]          d_reg,
    output logic [CW-1:0]          r_reg,
    output logic [CW-1:0]          p_reg,
    output logic [CW-1:0]          dk_reg,
    output logic [KW-1:0]          k_reg,
    output csct_pkg::flags_t       flags_reg
);
    import csct_pkg::*;

    logic [CW-1:0] delta;
    logic [CW-1:0] trial;
    logic          take;

    always_comb begin
        delta = (dk_in << (BIT + 3)) + (d_in << (2 * BIT + 2)) - (d_in << (BIT + 2));
        trial = p_in + delta + d_in;
        // once k reaches full scale, stop growing it
        take  = !k_in[KW-1] && (trial <= r_in);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg     <= d_in;
            r_reg     <= r_in;
            flags_reg <= flags_in;
            if (take) begin
                p_reg  <= p_in + delta;
                dk_reg <= dk_in + (d_in << BIT);
                k_reg  <= k_in | (KW'(1) << BIT);
            end else begin
                p_reg  <= p_in;
                dk_reg <= dk_in;
                k_reg  <= k_in;
            end
        end
    end

endmodule

[rtl/core/csct_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_chk - port-level checks for collins_soper_cos_theta
// Watches the stream and configuration ports; attached by bind.
// ----------------------------------------------------------------------------
module csct_chk #(
    parameter int MOMENTUM_WIDTH = csct_pkg::MOMENTUM_WIDTH_DEF,
    parameter int COS_FRAC_BITS  = csct_pkg::COS_FRAC_BITS_DEF,
    localparam int S_DW = ((8 * MOMENTUM_WIDTH - 2 + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [S_DW-1:0]                s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [csct_pkg::COS_WIDTH-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           cfg_data
);
    import csct_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a bad denominator always reads as zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad kinematics with nonzero cos_theta");

    // an empty output never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // reset drops everything in flight
    a_reset_flush: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result present right after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind collins_soper_cos_theta csct_chk #(
    .MOMENTUM_WIDTH(MOMENTUM_WIDTH),
    .COS_FRAC_BITS (COS_FRAC_BITS)
) u_csct_chk (.*);
